>>> rtl/sphere_segment_intersect_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sphere segment intersect block
// Concurrent property wrappers, removed in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SPHERE_SEGMENT_INTERSECT_ASSERT_SVH
`define SPHERE_SEGMENT_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
// condition a implies condition b in the same cycle
`define SSI_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");
// condition a implies condition b in the next cycle
`define SSI_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");
`else
`define SSI_ASSERT_SAME(label, clk, rst, a, b)
`define SSI_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/ssi_pkg.sv
// ---------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the sphere segment intersect block.
// ---------------------------------------------------------------------------
package ssi_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   // stages held in each pipeline section
   localparam int SECTION_STAGES = 3;

   // load enables and incoming valid for one three-stage section
   typedef struct packed {
      logic                      valid;
      logic [SECTION_STAGES-1:0] load;
   } ssi_ctrl_type;

endpackage

>>> rtl/ssi_front.sv
// ---------------------------------------------------------------------------
// ssi_front
// Stages one to three: differences, coordinate products, dot-product sums.
// ---------------------------------------------------------------------------
module ssi_front #(
   parameter int CW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssi_pkg::ssi_ctrl_type                ctrl,
   output logic [ssi_pkg::SECTION_STAGES-1:0]   valid,
   input  logic signed [CW-1:0]                 start_x,
   input  logic signed [CW-1:0]                 start_y,
   input  logic signed [CW-1:0]                 start_z,
   input  logic signed [CW-1:0]                 end_x,
   input  logic signed [CW-1:0]                 end_y,
   input  logic signed [CW-1:0]                 end_z,
   input  logic signed [CW-1:0]                 center_x,
   input  logic signed [CW-1:0]                 center_y,
   input  logic signed [CW-1:0]                 center_z,
   input  logic [CW-2:0]                        sphere_radius,
   output logic signed [2*CW+3:0]               coef_a,
   output logic signed [2*CW+3:0]               coef_h,
   output logic signed [2*CW+3:0]               coef_c
);
   import ssi_pkg::*;

   localparam int UW = CW + 1;
   localparam int PW = 2 * UW;
   localparam int AW = PW + 2;
   localparam int RW = CW - 1;

   logic [SECTION_STAGES-1:0] valid_ff, valid_in;

   logic signed [UW-1:0] ux_ff, uy_ff, uz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [UW-1:0] ux_in, uy_in, uz_in, dx_in, dy_in, dz_in;
   logic [RW-1:0]        r_ff;

   logic signed [PW-1:0] uu_x_ff, uu_y_ff, uu_z_ff, ud_x_ff, ud_y_ff, ud_z_ff;
   logic signed [PW-1:0] dd_x_ff, dd_y_ff, dd_z_ff;
   logic [2*RW-1:0]      rr_ff;

   logic signed [AW-1:0] a_ff, h_ff, c_ff, a_in, h_in, c_in;

   // advance valid bits
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load[0]) begin
         valid_in[0] = ctrl.valid;
      end
      if (ctrl.load[1]) begin
         valid_in[1] = valid_ff[0];
      end
      if (ctrl.load[2]) begin
         valid_in[2] = valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage one: segment direction and start offset from centre
   assign ux_in = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
   assign uy_in = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
   assign uz_in = {end_z[CW-1], end_z} - {start_z[CW-1], start_z};
   assign dx_in = {start_x[CW-1], start_x} - {center_x[CW-1], center_x};
   assign dy_in = {start_y[CW-1], start_y} - {center_y[CW-1], center_y};
   assign dz_in = {start_z[CW-1], start_z} - {center_z[CW-1], center_z};

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         uz_ff <= uz_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         r_ff  <= sphere_radius;
      end
   end

   // stage two: component products
   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         uu_x_ff <= PW'(ux_ff) * PW'(ux_ff);
         uu_y_ff <= PW'(uy_ff) * PW'(uy_ff);
         uu_z_ff <= PW'(uz_ff) * PW'(uz_ff);
         ud_x_ff <= PW'(ux_ff) * PW'(dx_ff);
         ud_y_ff <= PW'(uy_ff) * PW'(dy_ff);
         ud_z_ff <= PW'(uz_ff) * PW'(dz_ff);
         dd_x_ff <= PW'(dx_ff) * PW'(dx_ff);
         dd_y_ff <= PW'(dy_ff) * PW'(dy_ff);
         dd_z_ff <= PW'(dz_ff) * PW'(dz_ff);
         rr_ff   <= (2*RW)'(r_ff) * (2*RW)'(r_ff);
      end
   end

   // stage three: quadratic coefficients
   assign a_in = AW'(uu_x_ff) + AW'(uu_y_ff) + AW'(uu_z_ff);
   assign h_in = AW'(ud_x_ff) + AW'(ud_y_ff) + AW'(ud_z_ff);
   assign c_in = AW'(dd_x_ff) + AW'(dd_y_ff) + AW'(dd_z_ff)
               - $signed({{(AW-2*RW){1'b0}}, rr_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         a_ff <= a_in;
         h_ff <= h_in;
         c_ff <= c_in;
      end
   end

   assign valid  = valid_ff;
   assign coef_a = a_ff;
   assign coef_h = h_ff;
   assign coef_c = c_ff;

endmodule

>>> rtl/ssi_disc.sv
// ---------------------------------------------------------------------------
// ssi_disc
// Stages four to six: split wide products, discriminant sign, root tests.
// ---------------------------------------------------------------------------
module ssi_disc #(
   parameter int CW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssi_pkg::ssi_ctrl_type                ctrl,
   output logic [ssi_pkg::SECTION_STAGES-1:0]   valid,
   input  logic signed [2*CW+3:0]               coef_a,
   input  logic signed [2*CW+3:0]               coef_h,
   input  logic signed [2*CW+3:0]               coef_c,
   output logic                                 hit
);
   import ssi_pkg::*;

   localparam int AW = 2 * CW + 4;
   localparam int K  = AW / 2;
   localparam int HW = AW - K;
   localparam int DW = 2 * AW + 2;
   localparam int QW = AW + 2;

   logic [SECTION_STAGES-1:0] valid_ff, valid_in;

   logic signed [HW-1:0] a_hi, h_hi;
   logic signed [K:0]    a_lo, h_lo, c_lo;
   logic signed [HW-1:0] c_hi;

   logic signed [2*HW-1:0] hh_hh_ff, ac_hh_ff;
   logic signed [HW+K:0]   hh_hl_ff, ac_hl_ff, ac_lh_ff;
   logic signed [2*K+1:0]  hh_ll_ff, ac_ll_ff;

   logic signed [QW-1:0] ah_sum, q_sum;
   logic [4:0] flag4_ff, flag4_in, flag5_ff;
   logic       a_nz4_ff, a_nz5_ff;
   logic       q_nz4_ff, q_nz5_ff;

   logic signed [DW-1:0] hh_ff, ac_ff, hh_in, ac_in, dsc;
   logic first, second, hit_ff, hit_in;

   // advance valid bits
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load[0]) begin
         valid_in[0] = ctrl.valid;
      end
      if (ctrl.load[1]) begin
         valid_in[1] = valid_ff[0];
      end
      if (ctrl.load[2]) begin
         valid_in[2] = valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage four: split operands into signed high and unsigned low halves
   assign a_hi = coef_a[AW-1:K];
   assign h_hi = coef_h[AW-1:K];
   assign c_hi = coef_c[AW-1:K];
   assign a_lo = $signed({1'b0, coef_a[K-1:0]});
   assign h_lo = $signed({1'b0, coef_h[K-1:0]});
   assign c_lo = $signed({1'b0, coef_c[K-1:0]});

   // root-bound tests reduce to signs of a + h and a + 2h + c
   assign ah_sum = QW'(coef_a) + QW'(coef_h);
   assign q_sum  = ah_sum + QW'(coef_h) + QW'(coef_c);

   // flags: h <= 0, c <= 0, c >= 0, a + h >= 0, a + 2h + c >= 0 (bit 4 of pair)
   always_comb begin
      flag4_in[0] = coef_h[AW-1] | (coef_h == '0);
      flag4_in[1] = coef_c[AW-1] | (coef_c == '0);
      flag4_in[2] = ~coef_c[AW-1];
      flag4_in[3] = ~ah_sum[QW-1];
      flag4_in[4] = ~q_sum[QW-1];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         hh_hh_ff <= (2*HW)'(h_hi) * (2*HW)'(h_hi);
         hh_hl_ff <= (HW+K+1)'(h_hi) * (HW+K+1)'(h_lo);
         hh_ll_ff <= (2*K+2)'(h_lo) * (2*K+2)'(h_lo);
         ac_hh_ff <= (2*HW)'(a_hi) * (2*HW)'(c_hi);
         ac_hl_ff <= (HW+K+1)'(a_hi) * (HW+K+1)'(c_lo);
         ac_lh_ff <= (HW+K+1)'(a_lo) * (HW+K+1)'(c_hi);
         ac_ll_ff <= (2*K+2)'(a_lo) * (2*K+2)'(c_lo);
         flag4_ff <= flag4_in;
         a_nz4_ff <= (coef_a != '0);
         q_nz4_ff <= (q_sum != '0);
      end
   end

   // stage five: assemble h*h and a*c
   assign hh_in = (DW'(hh_hh_ff) <<< (2*K)) + ((DW'(hh_hl_ff) + DW'(hh_hl_ff)) <<< K)
                + DW'(hh_ll_ff);
   assign ac_in = (DW'(ac_hh_ff) <<< (2*K)) + ((DW'(ac_hl_ff) + DW'(ac_lh_ff)) <<< K)
                + DW'(ac_ll_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         hh_ff    <= hh_in;
         ac_ff    <= ac_in;
         flag5_ff <= flag4_ff;
         a_nz5_ff <= a_nz4_ff;
         q_nz5_ff <= q_nz4_ff;
      end
   end

   // stage six: discriminant sign and root interval decision
   assign dsc = hh_ff - ac_ff;
   assign first  = (flag5_ff[0] | flag5_ff[1]) & flag5_ff[3] & flag5_ff[4];
   assign second = flag5_ff[0] & flag5_ff[2]
                 & (flag5_ff[3] | ~flag5_ff[4] | ~q_nz5_ff);
   assign hit_in = a_nz5_ff & ~dsc[DW-1] & (first | second);

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         hit_ff <= hit_in;
      end
   end

   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

>>> rtl/sphere_segment_intersect.sv
// Sphere segment intersect: tests each streamed segment against one sphere
// held in configuration registers and returns a one-bit hit per segment, in
// order. The test is exact integer arithmetic on the Q10.6 coordinates. The
// pipeline is six register stages deep; one segment is taken every cycle while
// the result side keeps up. Each stage holds its own valid bit, so empty stages
// fill while the output waits. Write the sphere only while no segment is in
// flight.
// ---------------------------------------------------------------------------
// sphere_segment_intersect
// Top level: stream ports, sphere registers, stall control and checks.
// ---------------------------------------------------------------------------
module sphere_segment_intersect #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: hit
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_wdata
);
   import ssi_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int AW = 2 * CW + 4;

   logic signed [CW-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [CW-2:0]        radius_ff;

   ssi_ctrl_type front_ctrl, disc_ctrl;
   logic [SECTION_STAGES-1:0] front_valid, disc_valid;
   logic [2*SECTION_STAGES-1:0] vld, rdy;
   logic signed [AW-1:0] coef_a, coef_h, coef_c;
   logic hit;

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[CW-2:0];
            default:      center_x_ff <= center_x_ff;
         endcase
      end
   end

   // a stage loads when empty or when the stage after it moves
   assign vld = {disc_valid, front_valid};
   always_comb begin
      rdy[2*SECTION_STAGES-1] = ~vld[2*SECTION_STAGES-1] | rsp_tready;
      for (int i = 2*SECTION_STAGES-2; i >= 0; i--) begin
         rdy[i] = ~vld[i] | rdy[i+1];
      end
   end

   assign front_ctrl.valid = req_tvalid;
   assign front_ctrl.load  = rdy[SECTION_STAGES-1:0];
   assign disc_ctrl.valid  = vld[SECTION_STAGES-1];
   assign disc_ctrl.load   = rdy[2*SECTION_STAGES-1:SECTION_STAGES];

   ssi_front #(.CW(CW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (front_ctrl),
      .valid         (front_valid),
      .start_x       (req_tdata[0*CW +: CW]),
      .start_y       (req_tdata[1*CW +: CW]),
      .start_z       (req_tdata[2*CW +: CW]),
      .end_x         (req_tdata[3*CW +: CW]),
      .end_y         (req_tdata[4*CW +: CW]),
      .end_z         (req_tdata[5*CW +: CW]),
      .center_x      (center_x_ff),
      .center_y      (center_y_ff),
      .center_z      (center_z_ff),
      .sphere_radius (radius_ff),
      .coef_a        (coef_a),
      .coef_h        (coef_h),
      .coef_c        (coef_c)
   );

   ssi_disc #(.CW(CW)) u_disc (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (disc_ctrl),
      .valid  (disc_valid),
      .coef_a (coef_a),
      .coef_h (coef_h),
      .coef_c (coef_c),
      .hit    (hit)
   );

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld[2*SECTION_STAGES-1];
   assign rsp_tdata  = {7'd0, hit};

`include "sphere_segment_intersect_assert.svh"

   // input side only blocks when every stage holds an item
   `SSI_ASSERT_SAME(a_full_stall, clock, reset, !req_tready, &vld)
   // an accepted transfer lands in the first stage
   `SSI_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, vld[0])

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segment against sphere collision testbench
// Streams segments through the block under several sphere settings, predicts
// each hit bit with exact wide integer arithmetic, and checks every result in
// order. Both stream sides pause at random; the result side also holds off
// for a long stretch once, so that the pipeline fills and stalls its input.
// ---------------------------------------------------------------------------
module testbench;
   import ssi_pkg::*;

   localparam int CW      = 16;
   localparam int LATENCY = 6;

   // one segment: start and end points
   typedef struct {
      logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
   } segment_type;

   // directed row: segment plus expected hit where it is obvious (-1: predict)
   typedef struct {
      segment_type seg;
      int          hit;
   } seg_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [95:0]       req_tdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = CSR_CENTER_X;
   logic [CW-1:0]     csr_wdata = '0;

   // sphere copy held by the predictor, at reset values until written
   logic signed [CW-1:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
   logic [CW-2:0]        sph_r = '0;

   bit  hit_queue[$];
   int  errors = 0;
   int  hits_seen = 0;
   int  results_seen = 0;
   bit  hold_off = 1'b0;

   sphere_segment_intersect #(.COORD_WIDTH(CW)) DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // exact hit test: discriminant and root bounds on 128-bit integers
   function automatic bit segment_hits(segment_type s);
      logic signed [127:0] ux, uy, uz, dx, dy, dz, a, h, c, dsc, t1, t2;
      bit first, second;
      ux = s.ex - s.sx;  uy = s.ey - s.sy;  uz = s.ez - s.sz;
      dx = s.sx - sph_cx; dy = s.sy - sph_cy; dz = s.sz - sph_cz;
      a = ux*ux + uy*uy + uz*uz;
      h = ux*dx + uy*dy + uz*dz;
      c = dx*dx + dy*dy + dz*dz - $signed({1'b0, sph_r}) * $signed({1'b0, sph_r});
      if (a == 0) return 1'b0;
      dsc = h*h - a*c;
      if (dsc < 0) return 1'b0;
      // root (-h + s)/a in [0,1]: h <= s <= a + h
      t1 = a + h;
      first = (h <= 0 || dsc >= h*h) && (t1 >= 0 && dsc <= t1*t1);
      // root (-h - s)/a in [0,1]: -h - a <= s <= -h
      t2 = -h - a;
      second = (-h >= 0 && dsc <= h*h) && (t2 <= 0 || dsc >= t2*t2);
      return first || second;
   endfunction

   task automatic write_sphere(logic signed [CW-1:0] cx, cy, cz, logic [CW-2:0] r);
      logic [CW-1:0] vals[4];
      vals = '{cx, cy, cz, {1'b0, r}};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      sph_cx = cx; sph_cy = cy; sph_cz = cz; sph_r = r;
   endtask

   // offer one segment after a random gap and wait for the transfer
   task automatic send_segment(segment_type s, int want);
      bit exp;
      int idle;
      idle = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tdata  <= {s.ez, s.ey, s.ex, s.sz, s.sy, s.sx};
      req_tvalid <= 1'b1;
      exp = segment_hits(s);
      if (want >= 0 && exp != want[0]) begin
         $error("directed row disagrees: hit expected %0d, predicted %0d", want, exp);
         errors++;
      end
      hit_queue.push_back(want >= 0 ? want[0] : exp);
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every result has come back and the pipeline is empty
   task automatic drain;
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic segment_type random_segment(int mode);
      segment_type s;
      int span;
      if (mode == 0) begin
         // full range noise
         s = '{CW'($urandom), CW'($urandom), CW'($urandom),
               CW'($urandom), CW'($urandom), CW'($urandom)};
      end else begin
         // points scattered around the sphere so both outcomes occur
         span = int'(sph_r) * 2 + 64;
         s.sx = sph_cx + CW'($urandom_range(0, 2*span) - span);
         s.sy = sph_cy + CW'($urandom_range(0, 2*span) - span);
         s.sz = sph_cz + CW'($urandom_range(0, 2*span) - span);
         s.ex = sph_cx + CW'($urandom_range(0, 2*span) - span);
         s.ey = sph_cy + CW'($urandom_range(0, 2*span) - span);
         s.ez = sph_cz + CW'($urandom_range(0, 2*span) - span);
         if (mode == 2) begin
            s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
         end
      end
      return s;
   endfunction

   // result side: random stalls, one long hold-off, in-order check
   initial begin
      bit exp;
      int idle;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         // idle before taking the next result
         idle = $urandom_range(0, 13) * ($urandom_range(0, 3) == 0);
         if (idle > 0) begin
            rsp_tready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (hit_queue.size() == 0) begin
            $error("result with none expected: hit %0d", rsp_tdata[0]);
            errors++;
         end else begin
            exp = hit_queue.pop_front();
            results_seen++;
            hits_seen += rsp_tdata[0];
            if (rsp_tdata[0] !== exp) begin
               $error("hit mismatch: expected %0d, actual %0d", exp, rsp_tdata[0]);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      seg_row_type rows[$];
      localparam logic signed [CW-1:0] MX = 16'sh7fff, MN = -16'sh8000;
      // sphere at origin, radius 64 (one unit)
      rows = '{
         '{'{0, 0, 0, 0, 0, 0}, 0},                 // zero length at centre
         '{'{-128, 0, 0, 128, 0, 0}, 1},            // straight through
         '{'{-10, 0, 0, 10, 0, 0}, 0},              // wholly inside
         '{'{-128, 64, 0, 128, 64, 0}, 1},          // tangent at top
         '{'{-128, 65, 0, 128, 65, 0}, 0},          // just misses
         '{'{64, 0, 0, 200, 0, 0}, 1},              // starts on surface
         '{'{200, 0, 0, 64, 0, 0}, 1},              // ends on surface
         '{'{200, 0, 0, 65, 0, 0}, 0},              // stops short
         '{'{0, 0, 0, 0, 0, 500}, 1},               // leaves through z
         '{'{0, 0, -500, 0, 0, 0}, 1},              // enters through z
         '{'{0, 0, 0, 0, 50, 0}, -1},
         '{'{MN, MN, MN, MX, MX, MX}, 1},           // longest diagonal
         '{'{MX, MX, MX, MN, MN, MN}, 1},
         '{'{MN, MN, MN, MN, MN, MN}, 0},
         '{'{MX, MN, MX, MX, MN, MN}, 0},
         '{'{MX, MX, MX, MX, MX, MX}, 0},
         '{'{MN, 0, 0, MX, 0, 0}, 1}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // registers still at reset: radius zero, only exact touches hit
      send_segment('{-5, 0, 0, 5, 0, 0}, 1);
      send_segment('{-5, 1, 0, 5, 1, 0}, 0);
      drain();
      write_sphere(0, 0, 0, 64);
      foreach (rows[i]) send_segment(rows[i].seg, rows[i].hit);
      drain();

      // random phases through several spheres, extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_sphere(16'sh7fff, -16'sh8000, 16'sh7fff, 15'h7fff);
            1: write_sphere(-16'sh8000, 16'sh7fff, -16'sh8000, 0);
            2: write_sphere(CW'($urandom), CW'($urandom), CW'($urandom), 15'h7fff);
            default: write_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                                  15'($urandom_range(0, 4000)));
         endcase
         for (int n = 0; n < 205; n++) begin
            if (ph == 2 && n == 20) hold_off = 1'b1;
            // mostly segments near the sphere, some noise and zero length
            send_segment(random_segment($urandom_range(0, 9) < 2 ? 0 :
                                        ($urandom_range(0, 19) == 0 ? 2 : 1)), -1);
         end
         drain();
      end
      $display("Run covered %0d segments over 8 sphere settings, %0d of them hits.",
               results_seen, hits_seen);
      if (errors == 0 && hit_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> sphere_segment_intersect.f
+incdir+rtl
rtl/ssi_pkg.sv
rtl/ssi_front.sv
rtl/ssi_disc.sv
rtl/sphere_segment_intersect.sv
test/testbench.sv
